### rtl/packet_buffer_free_stack_pool_assert.svh
// Assertion macros used by the buffer pool back end.
`ifndef PACKET_BUFFER_FREE_STACK_POOL_ASSERT_SVH
`define PACKET_BUFFER_FREE_STACK_POOL_ASSERT_SVH
`ifndef SYNTHESIS
`define PBFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PBFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBFS_ASSERT(lbl, prop, msg)
`define PBFS_ASSERT_IMPL(lbl, ante, cons, msg)
`define PBFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/pbfs_pkg.sv
// Constants, codes and types of the buffer pool.
package pbfs_pkg;

    localparam int unsigned POOL_DEPTH    = 1024;
    localparam int unsigned MAX_BATCH     = 32;
    localparam int unsigned PAGE_BYTES    = 2097152;
    localparam int unsigned DEFAULT_BYTES = 2048;

    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned REQ_W     = 6;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned SIZE_W    = 22;
    localparam int unsigned ENTRIES_W = 11;
    localparam int unsigned ADDR64_W  = 64;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned COUNT_W   = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 64;

    localparam int unsigned ADDR_W  = $clog2(POOL_DEPTH);
    localparam int unsigned TOP_W   = $clog2(POOL_DEPTH + 1);
    localparam int unsigned BATCH_W = $clog2(MAX_BATCH + 1);
    localparam int unsigned GRANT_W = (TOP_W > REQ_W) ? ((TOP_W > BATCH_W) ? TOP_W : BATCH_W)
                                                      : ((REQ_W > BATCH_W) ? REQ_W : BATCH_W);
    localparam int unsigned PROD_W  = IDX_W + SIZE_W;
    localparam int unsigned FIT_W   = ENTRIES_W + SIZE_W;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned OUT_DEPTH   = 4;

    localparam logic [FUNC_W-1:0] FN_INIT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NOP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_VIRT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PHYS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 2'd3;

    localparam logic [1:0] KIND_INIT   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ALLOC  = 2'd2;
    localparam logic [1:0] KIND_FREE   = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [STATUS_W-1:0]  status;
        logic [ENTRIES_W-1:0] arg;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [ADDR64_W-1:0] va;
        logic [ADDR64_W-1:0] pa;
        logic                bvalid;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  fcount;
    } res_t;

endpackage

### rtl/pbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/pbfs_front.sv
// Front end: takes requests and classifies them into commands for the back end.
module pbfs_front (
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [pbfs_pkg::FUNC_W-1:0]     func,
    input  logic [pbfs_pkg::REQ_W-1:0]      request_count,
    input  logic [pbfs_pkg::IDX_W-1:0]      release_index,
    input  logic [pbfs_pkg::SIZE_W-1:0]     size_eff,
    input  logic [pbfs_pkg::ENTRIES_W-1:0]  pool_entries,
    input  logic                            q_full,
    output logic                            q_push,
    output pbfs_pkg::cmd_t                  q_data
);

    import pbfs_pkg::*;

    logic             size_ok;
    logic [FIT_W-1:0] pool_bytes;
    logic             too_large;
    logic             rel_bad;

    // page is a power of two, so the size divides it iff it is one too and no larger
    assign size_ok    = ((size_eff & (size_eff - SIZE_W'(1))) == '0)
                     && (32'(size_eff) <= PAGE_BYTES);
    assign pool_bytes = FIT_W'(pool_entries) * FIT_W'(size_eff);
    assign too_large  = (32'(pool_entries) > POOL_DEPTH) || (pool_bytes > FIT_W'(PAGE_BYTES));
    assign rel_bad    = 32'(release_index) >= POOL_DEPTH;

    assign cmd_ready = !q_full;
    assign q_push    = cmd_valid && !q_full && (func != FN_NOP);

    always_comb
    begin
        q_data.kind   = KIND_STATUS;
        q_data.status = ST_OK;
        q_data.arg    = '0;
        case (func)
            FN_INIT:
            begin
                if (!size_ok)
                begin
                    q_data.status = ST_BAD_SIZE;
                end
                else if (too_large)
                begin
                    q_data.status = ST_TOO_LARGE;
                end
                else
                begin
                    q_data.kind = KIND_INIT;
                    q_data.arg  = pool_entries;
                end
            end
            FN_ALLOC:
            begin
                if (request_count != '0)
                begin
                    q_data.kind = KIND_ALLOC;
                    q_data.arg  = ENTRIES_W'(request_count);
                end
            end
            FN_FREE:
            begin
                if (rel_bad)
                begin
                    q_data.status = ST_OVERFLOW;
                end
                else
                begin
                    q_data.kind = KIND_FREE;
                    q_data.arg  = ENTRIES_W'(release_index);
                end
            end
            default:
            begin
                q_data.kind = KIND_STATUS;
            end
        endcase
    end

endmodule

### rtl/pbfs_queue.sv
// Short command queue between front and back end.
module pbfs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pbfs_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output pbfs_pkg::cmd_t head
);

    import pbfs_pkg::*;

    localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/pbfs_back.sv
// Back end: free stack, batch pop sequencer, address pipeline and result queue.
`include "packet_buffer_free_stack_pool_assert.svh"
module pbfs_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  pbfs_pkg::cmd_t                     q_head,
    output logic                               q_pop,
    input  logic [pbfs_pkg::ADDR64_W-1:0]      base_virtual,
    input  logic [pbfs_pkg::ADDR64_W-1:0]      base_physical,
    input  logic [pbfs_pkg::SIZE_W-1:0]        size_eff,
    output logic                               res_valid,
    input  logic                               res_ready,
    output pbfs_pkg::res_t                     res_data
);

    import pbfs_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_RUN  = 1'b1;

    localparam int unsigned OPTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam int unsigned CRED_W = $clog2(OUT_DEPTH + 3);

    typedef struct packed {
        logic                bvalid;
        logic                virgin;
        logic [ADDR_W-1:0]   addr;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  fcount;
    } iss_t;

    typedef struct packed {
        logic                bvalid;
        logic [IDX_W-1:0]    idx;
        logic [PROD_W-1:0]   prod;
        logic                last;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  fcount;
    } mul_t;

    logic [0:0]          state_reg, state_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [TOP_W-1:0]    lw_reg, lw_next;
    logic [BATCH_W-1:0]  remain_reg, remain_next;
    logic [STATUS_W-1:0] run_status_reg, run_status_next;

    logic                p1_valid_reg;
    iss_t                p1_reg;
    logic                p2_valid_reg;
    mul_t                p2_reg;

    res_t                ofifo_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OCNT_W-1:0]   ocount_reg, ocount_next;

    logic [CRED_W-1:0]   inflight;
    logic                can_issue;
    logic                iss_valid;
    iss_t                iss;
    logic [TOP_W-1:0]    top_dec;
    logic [GRANT_W-1:0]  req_ext;
    logic [GRANT_W-1:0]  grant;

    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_rdata;

    logic [IDX_W-1:0]    idx_b;
    logic [PROD_W-1:0]   prod_b;
    res_t                push_entry;
    logic                res_pop;

    // entries below the low-water mark are untouched since init and read as their own index
    pbfs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (top_reg[ADDR_W-1:0]),
        .wr_data (q_head.arg[IDX_W-1:0]),
        .rd_en   (ram_re),
        .rd_addr (top_dec[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign inflight  = CRED_W'(ocount_reg) + CRED_W'(p1_valid_reg) + CRED_W'(p2_valid_reg);
    assign can_issue = inflight < CRED_W'(OUT_DEPTH);
    assign top_dec   = top_reg - TOP_W'(1);
    assign req_ext   = GRANT_W'(q_head.arg[REQ_W-1:0]);

    always_comb
    begin
        grant = req_ext;
        if (grant > GRANT_W'(MAX_BATCH))
        begin
            grant = GRANT_W'(MAX_BATCH);
        end
        if (grant > GRANT_W'(top_reg))
        begin
            grant = GRANT_W'(top_reg);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        top_next        = top_reg;
        lw_next         = lw_reg;
        remain_next     = remain_reg;
        run_status_next = run_status_reg;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        iss_valid       = 1'b0;
        iss.bvalid      = 1'b0;
        iss.virgin      = 1'b0;
        iss.addr        = '0;
        iss.last        = 1'b1;
        iss.status      = ST_OK;
        iss.fcount      = COUNT_W'(top_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && can_issue)
                begin
                    q_pop = 1'b1;
                    case (q_head.kind)
                        KIND_INIT:
                        begin
                            top_next   = TOP_W'(q_head.arg);
                            lw_next    = TOP_W'(q_head.arg);
                            iss_valid  = 1'b1;
                            iss.fcount = COUNT_W'(q_head.arg);
                        end
                        KIND_STATUS:
                        begin
                            iss_valid  = 1'b1;
                            iss.status = q_head.status;
                        end
                        KIND_FREE:
                        begin
                            iss_valid = 1'b1;
                            if (top_reg == TOP_W'(POOL_DEPTH))
                            begin
                                iss.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                top_next   = top_reg + TOP_W'(1);
                                iss.fcount = COUNT_W'(top_reg + TOP_W'(1));
                            end
                        end
                        KIND_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                iss_valid  = 1'b1;
                                iss.status = ST_NONE_FREE;
                            end
                            else
                            begin
                                remain_next     = BATCH_W'(grant);
                                run_status_next = (grant < req_ext) ? ST_SHORT : ST_OK;
                                state_next      = S_RUN;
                            end
                        end
                        default:
                        begin
                            iss_valid = 1'b0;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (can_issue)
                begin
                    ram_re      = 1'b1;
                    iss_valid   = 1'b1;
                    iss.bvalid  = 1'b1;
                    iss.virgin  = top_dec < lw_reg;
                    iss.addr    = top_dec[ADDR_W-1:0];
                    iss.last    = remain_reg == BATCH_W'(1);
                    iss.status  = run_status_reg;
                    iss.fcount  = COUNT_W'(top_dec);
                    top_next    = top_dec;
                    lw_next     = (top_dec < lw_reg) ? top_dec : lw_reg;
                    remain_next = remain_reg - BATCH_W'(1);
                    if (remain_reg == BATCH_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idx_b  = p1_reg.virgin ? IDX_W'(p1_reg.addr) : ram_rdata;
    assign prod_b = p1_reg.bvalid ? PROD_W'(idx_b) * PROD_W'(size_eff) : '0;

    always_comb
    begin
        push_entry.idx    = p2_reg.bvalid ? p2_reg.idx : '0;
        push_entry.va     = p2_reg.bvalid ? base_virtual + ADDR64_W'(p2_reg.prod) : '0;
        push_entry.pa     = p2_reg.bvalid ? base_physical + ADDR64_W'(p2_reg.prod) : '0;
        push_entry.bvalid = p2_reg.bvalid;
        push_entry.last   = p2_reg.last;
        push_entry.status = p2_reg.status;
        push_entry.fcount = p2_reg.fcount;
    end

    assign res_valid = ocount_reg != '0;
    assign res_data  = ofifo_reg[rd_ptr_reg];
    assign res_pop   = res_valid && res_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        ocount_next = ocount_reg;
        if (p2_valid_reg)
        begin
            wr_ptr_next = (wr_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + OPTR_W'(1);
        end
        if (res_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == OPTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + OPTR_W'(1);
        end
        if (p2_valid_reg && !res_pop)
        begin
            ocount_next = ocount_reg + OCNT_W'(1);
        end
        else if (res_pop && !p2_valid_reg)
        begin
            ocount_next = ocount_reg - OCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= TOP_W'(POOL_DEPTH);
            lw_reg         <= TOP_W'(POOL_DEPTH);
            remain_reg     <= '0;
            run_status_reg <= ST_OK;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            ocount_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            top_reg        <= top_next;
            lw_reg         <= lw_next;
            remain_reg     <= remain_next;
            run_status_reg <= run_status_next;
            p1_valid_reg   <= iss_valid;
            p2_valid_reg   <= p1_valid_reg;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            ocount_reg     <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg        <= iss;
        p2_reg.bvalid <= p1_reg.bvalid;
        p2_reg.idx    <= idx_b;
        p2_reg.prod   <= prod_b;
        p2_reg.last   <= p1_reg.last;
        p2_reg.status <= p1_reg.status;
        p2_reg.fcount <= p1_reg.fcount;
        if (p2_valid_reg)
        begin
            ofifo_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `PBFS_ASSERT(a_top_range, top_reg <= TOP_W'(POOL_DEPTH), "stack top beyond pool depth")
    `PBFS_ASSERT(a_lw_below_top, lw_reg <= top_reg, "low-water mark above stack top")
    `PBFS_ASSERT_IMPL(a_out_room, p2_valid_reg, (ocount_reg < OCNT_W'(OUT_DEPTH)) || res_pop, "result queue overrun")
    `PBFS_ASSERT_IMPL(a_run_grant, state_reg == S_RUN, (remain_reg != '0) && (GRANT_W'(remain_reg) <= GRANT_W'(top_reg)), "batch exceeds free entries")
    `PBFS_ASSERT_NEXT(a_pop_moves_top, (state_reg == S_RUN) && can_issue, top_reg == $past(top_reg) - TOP_W'(1), "pop did not lower stack top")

endmodule

### rtl/packet_buffer_free_stack_pool.sv
// Top level of the packet buffer pool: configuration registers and front/queue/back.
//
//   channel  direction  handshake               payload
//   cmd      in         cmd_valid / cmd_ready   func, request_count, release_index
//   res      out        res_valid / res_ready   buffer_index .. free_count
//   cfg      in         cfg_write               cfg_index, cfg_data
//
// Init, free and status requests are handled in S_IDLE; an allocate is set up in S_IDLE,
// then S_RUN pops one granted buffer per cycle (up to MAX_BATCH) unless the back end stalls.
// Each result passes the p1 and p2 registers and then the result queue on its way to res.
// No clearing pass after reset: unwritten stack entries are tracked by a low-water mark.
// Four results queued or in the pipeline stall the back end; a full command queue stalls cmd.
module packet_buffer_free_stack_pool (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [pbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbfs_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [pbfs_pkg::FUNC_W-1:0]       func,
    input  logic [pbfs_pkg::REQ_W-1:0]        request_count,
    input  logic [pbfs_pkg::IDX_W-1:0]        release_index,
    output logic                              res_valid,
    input  logic                              res_ready,
    output logic [pbfs_pkg::IDX_W-1:0]        buffer_index,
    output logic [pbfs_pkg::ADDR64_W-1:0]     virtual_address,
    output logic [pbfs_pkg::ADDR64_W-1:0]     physical_address,
    output logic                              buffer_valid,
    output logic                              last_of_run,
    output logic [pbfs_pkg::STATUS_W-1:0]     status,
    output logic [pbfs_pkg::COUNT_W-1:0]      free_count
);

    import pbfs_pkg::*;

    logic [ADDR64_W-1:0]  base_virtual_reg;
    logic [ADDR64_W-1:0]  base_physical_reg;
    logic [SIZE_W-1:0]    buffer_bytes_reg;
    logic [ENTRIES_W-1:0] pool_entries_reg;
    logic [SIZE_W-1:0]    size_eff;

    logic                 q_push;
    cmd_t                 q_data;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    cmd_t                 q_head;
    res_t                 res_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_virtual_reg  <= '0;
            base_physical_reg <= '0;
            buffer_bytes_reg  <= SIZE_W'(DEFAULT_BYTES);
            pool_entries_reg  <= ENTRIES_W'(POOL_DEPTH);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BASE_VIRT: base_virtual_reg  <= cfg_data;
                REG_BASE_PHYS: base_physical_reg <= cfg_data;
                REG_BUF_BYTES: buffer_bytes_reg  <= cfg_data[SIZE_W-1:0];
                REG_POOL_SIZE: pool_entries_reg  <= cfg_data[ENTRIES_W-1:0];
                default:       pool_entries_reg  <= pool_entries_reg;
            endcase
        end
    end

    assign size_eff = (buffer_bytes_reg == '0) ? SIZE_W'(DEFAULT_BYTES) : buffer_bytes_reg;

    pbfs_front u_front (
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .func          (func),
        .request_count (request_count),
        .release_index (release_index),
        .size_eff      (size_eff),
        .pool_entries  (pool_entries_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    pbfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    pbfs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .base_virtual  (base_virtual_reg),
        .base_physical (base_physical_reg),
        .size_eff      (size_eff),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_data      (res_data)
    );

    assign buffer_index     = res_data.idx;
    assign virtual_address  = res_data.va;
    assign physical_address = res_data.pa;
    assign buffer_valid     = res_data.bvalid;
    assign last_of_run      = res_data.last;
    assign status           = res_data.status;
    assign free_count       = res_data.fcount;

endmodule
